/* rtl/ssd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, command and register codes, and segment tables for the
// seven-segment display driver. No dependencies.
package ssd_pkg;

	localparam int NUM_MAX = 5;   // widest decimal number in digits
	localparam int NUM_IDX_W = 3; // index into the digit scratch
	localparam int VALUE_W = 16;
	localparam int RECIP_10 = 52429; // ceil(2^19 / 10)
	localparam int RECIP_SH = 19;

	localparam logic [1:0] CMD_RAW = 2'd0;
	localparam logic [1:0] CMD_NUM = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic REG_LEAD_ZERO = 1'b0;
	localparam logic REG_INVERT = 1'b1;

	localparam logic [7:0] SEG_DOT = 8'h80;
	localparam logic [7:0] SEG_BLANK = 8'h00;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic       start;
		logic [7:0] sel;
		logic [7:0] seg;
	} ser_req_t;

	typedef struct packed {
		logic busy;
	} ser_stat_t;

	function automatic logic [7:0] digit_code(input logic [3:0] d);
		logic [7:0] c;
		case (d)
			4'd0: c = 8'h3F;
			4'd1: c = 8'h06;
			4'd2: c = 8'h5B;
			4'd3: c = 8'h4F;
			4'd4: c = 8'h66;
			4'd5: c = 8'h6D;
			4'd6: c = 8'h7D;
			4'd7: c = 8'h07;
			4'd8: c = 8'h7F;
			4'd9: c = 8'h6F;
			default: c = SEG_BLANK;
		endcase
		return c;
	endfunction

	// Board wiring of the digit-select byte: bit sent at each step
	function automatic logic [2:0] sel_bit(input logic [2:0] k);
		logic [2:0] b;
		case (k)
			3'd0: b = 3'd4;
			3'd1: b = 3'd5;
			3'd2: b = 3'd6;
			3'd3: b = 3'd7;
			3'd4: b = 3'd0;
			3'd5: b = 3'd1;
			3'd6: b = 3'd2;
			3'd7: b = 3'd3;
			default: b = 3'd0;
		endcase
		return b;
	endfunction

	// Board wiring of the segment byte
	function automatic logic [2:0] seg_bit(input logic [2:0] k);
		logic [2:0] b;
		case (k)
			3'd0: b = 3'd5;
			3'd1: b = 3'd1;
			3'd2: b = 3'd6;
			3'd3: b = 3'd2;
			3'd4: b = 3'd7;
			3'd5: b = 3'd3;
			3'd6: b = 3'd4;
			3'd7: b = 3'd0;
			default: b = 3'd0;
		endcase
		return b;
	endfunction

endpackage

/* rtl/ssd_digit_unit.sv */
`timescale 1ns / 1ps
// Shared divide-by-ten unit: peels one decimal digit per step, least
// significant first. Depends on ssd_pkg.
module ssd_digit_unit (
	input  logic                         clk,
	input  logic                         load,
	input  logic [ssd_pkg::VALUE_W-1:0]  value,
	input  logic                         step,
	output logic [3:0]                   digit
);

	logic [ssd_pkg::VALUE_W-1:0]   quot_q;
	logic [2*ssd_pkg::VALUE_W-1:0] prod;
	logic [ssd_pkg::VALUE_W-1:0]   q;
	logic [ssd_pkg::VALUE_W-1:0]   q10;
	logic [ssd_pkg::VALUE_W-1:0]   rem;

	// x / 10 by reciprocal, exact over the full 16-bit range
	assign prod = quot_q * (2*ssd_pkg::VALUE_W)'(ssd_pkg::RECIP_10);
	assign q = ssd_pkg::VALUE_W'(prod >> ssd_pkg::RECIP_SH);
	assign q10 = (q << 3) + (q << 1);
	assign rem = quot_q - q10;
	assign digit = rem[3:0];

	always_ff @(posedge clk) begin
		if (load) begin
			quot_q <= value;
		end else if (step) begin
			quot_q <= q;
		end
	end

endmodule

/* rtl/ssd_serializer.sv */
`timescale 1ns / 1ps
// Sixteen-bit serializer with output register: digit select then segments,
// permuted by the board wiring. Depends on ssd_pkg.
module ssd_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  ssd_pkg::ser_req_t   req,
	input  logic                invert,
	output ssd_pkg::ser_stat_t  stat,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                serial_bit,
	output logic                latch
);

	logic       active_q;
	logic [3:0] cnt_q;
	logic [7:0] sel_q;
	logic [7:0] seg_q;
	logic       valid_q;
	logic       bit_q;
	logic       latch_q;
	logic       load_ok;
	logic       next_bit;

	assign load_ok = !valid_q || !out_stall;
	assign next_bit = (cnt_q[3] ? seg_q[ssd_pkg::seg_bit(cnt_q[2:0])]
		: sel_q[ssd_pkg::sel_bit(cnt_q[2:0])]) ^ invert;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q <= '0;
			end else if (active_q && load_ok) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					active_q <= 1'b0;
				end
			end
			if (active_q && load_ok) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sel_q <= req.sel;
			seg_q <= req.seg;
		end
		if (active_q && load_ok) begin
			bit_q <= next_bit;
			latch_q <= (cnt_q == 4'd15);
		end
	end

	assign stat.busy = active_q;
	assign out_valid = valid_q;
	assign serial_bit = bit_q;
	assign latch = latch_q;

endmodule

/* rtl/seven_segment_mux_display_driver.sv */
`timescale 1ns / 1ps
// Top level of the multiplexed seven-segment display driver.
// Depends on ssd_pkg, ssd_digit_unit and ssd_serializer.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transaction:
//   a raw segment write, a decimal number write or a refresh tick.
//   Output channel (out_valid / out_stall) carries one serial bit per
//   transaction; a tick yields sixteen, the last marked by latch.
//   An APB-style port writes the leading-zero enable (0x0) and invert_output
//   (0x4); pready is always high and reads return the register value.
// Sequencing:
//   Decimal write: one digit per cycle through the shared divide-by-ten
//   unit, then one buffer entry per cycle. Tick: a start cycle and then
//   one bit per cycle from the serializer while out_stall is low; the next
//   command is taken once the last bit has been loaded into the output
//   register. in_stall stays high while busy.
// Reset:
//   Clears the segment buffer (all blank), the scan position and the
//   leading-zero enable, and sets invert_output. No clearing pass is needed.
// Receiver stall:
//   Hold the current bit in the output register; the serializer waits and
//   in_stall stays high until the last bit has been loaded into the output
//   register.
module seven_segment_mux_display_driver #(
	parameter int DIGITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  position,
	input  logic [7:0]  segments,
	input  logic [15:0] value,
	input  logic [2:0]  digit_count,
	input  logic [1:0]  decimals,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        serial_bit,
	output logic        latch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	// Configuration registers
	logic lead_zero_q;
	logic invert_q;
	logic cfg_wr;

	// Display state
	logic [7:0]       seg_buf_q [DIGITS];
	logic [IDX_W-1:0] scan_q;

	// Sequencer
	ssd_pkg::state_t state_q;
	ssd_pkg::state_t state_d;
	logic [ssd_pkg::NUM_IDX_W-1:0] k_q;
	logic [ssd_pkg::NUM_IDX_W-1:0] i_q;
	logic [2:0]  width_q;
	logic [1:0]  dec_q;
	logic [3:0]  pos_q;
	logic        lead_q;
	logic [3:0]  digit_q [ssd_pkg::NUM_MAX];

	logic       accept;
	logic       raw_go;
	logic       num_go;
	logic       tick_go;
	logic       raw_in_range;
	logic [3:0] unit_digit;

	// Decimal write datapath
	logic [3:0] cur_d;
	logic       dotted;
	logic       keep;
	logic       last;
	logic       blank;
	logic [7:0] cur_code;
	logic [4:0] tgt;
	logic       tgt_in_range;

	ssd_pkg::ser_req_t  ser_req;
	ssd_pkg::ser_stat_t ser_stat;

	// APB: setup then access, never waits
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == ssd_pkg::REG_INVERT) ? {31'd0, invert_q}
		: {31'd0, lead_zero_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_zero_q <= 1'b0;
			invert_q <= 1'b1;
		end else if (cfg_wr) begin
			if (paddr[2] == ssd_pkg::REG_LEAD_ZERO) begin
				lead_zero_q <= pwdata[0];
			end else begin
				invert_q <= pwdata[0];
			end
		end
	end

	// Input handshake: one command at a time
	assign in_stall = (state_q != ssd_pkg::ST_IDLE) || ser_stat.busy;
	assign accept = in_valid && !in_stall;
	assign raw_go = accept && (cmd == ssd_pkg::CMD_RAW);
	assign num_go = accept && (cmd == ssd_pkg::CMD_NUM) && (digit_count != 3'd0)
		&& (digit_count <= 3'(ssd_pkg::NUM_MAX));
	assign tick_go = accept && (cmd == ssd_pkg::CMD_TICK);
	assign raw_in_range = (position != 4'd0) && (position <= 4'(DIGITS));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ssd_pkg::ST_IDLE: begin
				if (num_go) begin
					state_d = ssd_pkg::ST_DIV;
				end
			end
			ssd_pkg::ST_DIV: begin
				if (k_q == '0) begin
					state_d = ssd_pkg::ST_WRITE;
				end
			end
			ssd_pkg::ST_WRITE: begin
				if (i_q == (width_q - 3'd1)) begin
					state_d = ssd_pkg::ST_IDLE;
				end
			end
			default: state_d = ssd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Shared digit extraction, rightmost digit first
	ssd_digit_unit u_digit (
		.clk   (clk),
		.load  (num_go),
		.value (value),
		.step  (state_q == ssd_pkg::ST_DIV),
		.digit (unit_digit)
	);

	// Decimal point and leading-zero rules for the digit at i_q
	assign cur_d = digit_q[i_q];
	assign dotted = ((width_q == 3'd2) && (dec_q == 2'd1) && (i_q == 3'd0))
		|| ((width_q == 3'd3) && (dec_q == 2'd2) && (i_q == 3'd0))
		|| ((width_q == 3'd3) && (dec_q == 2'd1) && (i_q == 3'd1));
	assign keep = (width_q == 3'd3) && (dec_q != 2'd0) && (i_q == 3'd1);
	assign last = (i_q == (width_q - 3'd1));
	assign blank = !dotted && !last && !keep && lead_q && (cur_d == 4'd0);
	assign cur_code = dotted ? (ssd_pkg::digit_code(cur_d) | ssd_pkg::SEG_DOT)
		: (blank ? ssd_pkg::SEG_BLANK : ssd_pkg::digit_code(cur_d));
	assign tgt = 5'(pos_q) + 5'(i_q);
	assign tgt_in_range = (tgt != 5'd0) && (tgt <= 5'(DIGITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			i_q <= '0;
			lead_q <= 1'b0;
		end else begin
			case (state_q)
				ssd_pkg::ST_IDLE: begin
					if (num_go) begin
						k_q <= digit_count - 3'd1;
					end
				end
				ssd_pkg::ST_DIV: begin
					k_q <= k_q - 3'd1;
					i_q <= '0;
					lead_q <= !lead_zero_q;
				end
				ssd_pkg::ST_WRITE: begin
					i_q <= i_q + 3'd1;
					if (!blank) begin
						lead_q <= 1'b0;
					end
				end
				default: begin
					k_q <= '0;
				end
			endcase
		end
	end

	// Command fields and digit scratch
	always_ff @(posedge clk) begin
		if (num_go) begin
			width_q <= digit_count;
			dec_q <= decimals;
			pos_q <= position;
		end
		if (state_q == ssd_pkg::ST_DIV) begin
			digit_q[k_q] <= unit_digit;
		end
	end

	// Segment buffer and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < DIGITS; n++) begin
				seg_buf_q[n] <= ssd_pkg::SEG_BLANK;
			end
			scan_q <= '0;
		end else begin
			if (raw_go && raw_in_range) begin
				seg_buf_q[IDX_W'(position - 4'd1)] <= segments;
			end else if ((state_q == ssd_pkg::ST_WRITE) && tgt_in_range) begin
				seg_buf_q[IDX_W'(tgt - 5'd1)] <= cur_code;
			end
			if (tick_go) begin
				scan_q <= (scan_q == IDX_W'(DIGITS - 1)) ? '0 : scan_q + 1'b1;
			end
		end
	end

	// Hand the scanned digit to the serializer
	assign ser_req.start = tick_go;
	assign ser_req.sel = 8'd1 << scan_q;
	assign ser_req.seg = seg_buf_q[scan_q];

	ssd_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (ser_req),
		.invert     (invert_q),
		.stat       (ser_stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.serial_bit (serial_bit),
		.latch      (latch)
	);

	// Decimal work never overlaps a running tick
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ssd_pkg::ST_IDLE) |-> !ser_stat.busy)
		else $error("decimal write overlaps serializer");

	// An accepted tick starts the serializer in the next cycle
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go |=> ser_stat.busy)
		else $error("tick did not start serializer");

	// Scan position advances by one per tick and wraps at the last digit
	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go |=> (scan_q == (($past(scan_q) == IDX_W'(DIGITS - 1)) ? '0
			: $past(scan_q) + 1'b1)))
		else $error("scan position did not advance");

endmodule
